/* hw/rtl/dwpi_pkg.sv */
package dwpi_pkg;

  localparam int SpeedW = 16;
  localparam int ErrW   = SpeedW + 1;
  localparam int IntegW = 32;
  localparam int DriveW = 12;
  localparam int SumW   = 22;
  localparam int MagW   = SumW - 1;
  localparam int ThrW   = 24;
  localparam int QuotW  = 18;
  localparam int RecipShift = 24;

  localparam logic signed [DriveW-1:0] DriveMax = 12'sd2047;
  localparam logic signed [DriveW-1:0] DriveMin = -12'sd2047;
  localparam logic signed [ThrW-1:0]   LimitUp  = 24'sd2048;
  localparam logic signed [ThrW-1:0]   LimitDn  = -24'sd2048;
  localparam logic [MagW-1:0]          RecipTen = 21'd1677722;

  typedef struct packed {
    logic signed [IntegW-1:0] integ_next;
    logic signed [SumW-1:0]   sum;
    logic signed [ErrW-1:0]   err;
    logic                     sat_hi;
    logic                     sat_lo;
  } wheel_mid_t;

  // Error, new integral and the clamp decision. Clamping is decided by comparing the
  // integral against thresholds derived from the error, so no division is needed here.
  function automatic wheel_mid_t wheel_update(input logic signed [IntegW-1:0] integ,
                                              input logic [SpeedW-1:0] target,
                                              input logic [SpeedW-1:0] measured);
    wheel_mid_t             r;
    logic signed [ErrW-1:0]   err;
    logic signed [IntegW-1:0] sum;
    logic signed [ThrW-1:0]   err_x;
    logic signed [ThrW-1:0]   k_hi;
    logic signed [ThrW-1:0]   k_lo;
    logic signed [ThrW-1:0]   thr_hi;
    logic signed [ThrW-1:0]   thr_lo;
    err    = $signed({target[SpeedW-1], target}) - $signed({measured[SpeedW-1], measured});
    sum    = integ + IntegW'(err);
    err_x  = ThrW'(err);
    k_hi   = LimitUp - (err_x <<< 1);
    k_lo   = LimitDn - (err_x <<< 1);
    thr_hi = (k_hi <<< 3) + (k_hi <<< 1) - ((k_hi <= 0) ? 24'sd9 : 24'sd0);
    thr_lo = (k_lo <<< 3) + (k_lo <<< 1) + ((k_lo >= 0) ? 24'sd9 : 24'sd0);
    r.sat_hi     = sum >= IntegW'(thr_hi);
    r.sat_lo     = sum <= IntegW'(thr_lo);
    r.integ_next = (r.sat_hi || r.sat_lo) ? integ : sum;
    r.sum        = sum[SumW-1:0];
    r.err        = err;
    return r;
  endfunction

  // Drive from a registered middle result. The sum is small whenever it is not clamped.
  function automatic logic [DriveW-1:0] wheel_drive(input wheel_mid_t m);
    logic [SumW-1:0]           mag;
    logic [2*MagW-1:0]         prod;
    logic [QuotW-1:0]          quot;
    logic signed [QuotW:0]     quot_s;
    logic signed [QuotW:0]     drive;
    logic [DriveW-1:0]         res;
    mag    = m.sum[SumW-1] ? SumW'(-m.sum) : m.sum;
    prod   = (2*MagW)'(mag[MagW-1:0]) * (2*MagW)'(RecipTen);
    quot   = prod[RecipShift+QuotW-1:RecipShift];
    quot_s = m.sum[SumW-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    drive  = $signed({m.err[ErrW-1], m.err, 1'b0}) + quot_s;
    if (m.sat_hi) begin
      res = DriveMax;
    end else if (m.sat_lo) begin
      res = DriveMin;
    end else begin
      res = drive[DriveW-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/dual_wheel_pi_speed_control.sv */
// Channel   Dir  tdata fields (lowest bit first)                            Width
// s_axis    in   target_right, measured_right, target_left, measured_left  64
// m_axis    out  drive_right, drive_left                                    24
//
// Three register stages: input, middle and output. An item is accepted every cycle
// while the output side does not stall, and its result passes from the input register
// through the middle register to the output register.
// The integrals update from the input register as an item moves on, which sets the rate.
// Reset clears both integrals and empties all stages.
// A stall on the output fills the stages and then holds s_axis_tready low.
module dual_wheel_pi_speed_control
  import dwpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_right[15:0], measured_right[31:16], target_left[47:32], measured_left[63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_right[11:0], drive_left[23:12]
  output logic [23:0] m_axis_tdata
);

  logic        in_valid_q, mid_valid_q, out_valid_q;
  logic [63:0] in_data_q;
  logic signed [IntegW-1:0] integ_r_q, integ_l_q;
  wheel_mid_t  mid_r_d, mid_l_d, mid_r_q, mid_l_q;
  logic [23:0] out_data_q;
  logic        take_in, adv_mid, adv_out;

  assign adv_out       = mid_valid_q && (!out_valid_q || m_axis_tready);
  assign adv_mid       = in_valid_q && (!mid_valid_q || adv_out);
  assign s_axis_tready = !in_valid_q || adv_mid;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  assign mid_r_d = wheel_update(integ_r_q, in_data_q[15:0], in_data_q[31:16]);
  assign mid_l_d = wheel_update(integ_l_q, in_data_q[47:32], in_data_q[63:48]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      integ_r_q   <= '0;
      integ_l_q   <= '0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (adv_mid) begin
        in_valid_q <= 1'b0;
      end
      if (adv_mid) begin
        mid_valid_q <= 1'b1;
        integ_r_q   <= mid_r_d.integ_next;
        integ_l_q   <= mid_l_d.integ_next;
      end else if (adv_out) begin
        mid_valid_q <= 1'b0;
      end
      if (adv_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_data_q <= s_axis_tdata;
    end
    if (adv_mid) begin
      mid_r_q <= mid_r_d;
      mid_l_q <= mid_l_d;
    end
    if (adv_out) begin
      out_data_q <= {wheel_drive(mid_l_q), wheel_drive(mid_r_q)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* bench/dual_wheel_pi_speed_control_test.sv */
`timescale 1ns / 100ps

module dual_wheel_pi_speed_control_test;
  import dwpi_pkg::*;

  localparam int PGain      = 2;
  localparam int IntegDiv   = 10;
  localparam int MaxGap     = 16;
  localparam int ChunkItems = 100;
  localparam int NumChunks  = 11;
  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 2000;
  localparam int DrainWait  = 10;
  localparam int ReportMax  = 10;

  typedef enum int {
    SpeedsRandom,
    SpeedsSteady,
    SpeedsWindup
  } speeds_kind_e;

  class wheel_drive_tracker;
    logic [31:0] integ_right;
    logic [31:0] integ_left;
    logic [23:0] drive_due_q[$];
    int unsigned mismatches;

    function new();
      integ_right = '0;
      integ_left  = '0;
      mismatches  = 0;
    endfunction

    function logic [DriveW-1:0] predict_wheel(inout logic [31:0] integ,
                                              input logic [15:0] tgt,
                                              input logic [15:0] meas);
      longint      err;
      longint      drive;
      logic [31:0] err_bits;
      err      = longint'($signed(tgt)) - longint'($signed(meas));
      err_bits = err[31:0];
      integ    = integ + err_bits;
      drive    = PGain * err + longint'($signed(integ)) / IntegDiv;
      if (drive > longint'(DriveMax)) begin
        drive = longint'(DriveMax);
        integ = integ - err_bits;
      end else if (drive < longint'(DriveMin)) begin
        drive = longint'(DriveMin);
        integ = integ - err_bits;
      end
      return drive[DriveW-1:0];
    endfunction

    function void take_speeds(logic [63:0] speeds);
      logic [DriveW-1:0] dr;
      logic [DriveW-1:0] dl;
      dr = predict_wheel(integ_right, speeds[15:0], speeds[31:16]);
      dl = predict_wheel(integ_left, speeds[47:32], speeds[63:48]);
      drive_due_q.push_back({dl, dr});
    endfunction

    function void compare_drive(logic [23:0] got);
      logic [23:0] want;
      if (drive_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("Unexpected drive transaction: right %0d left %0d",
                   $signed(got[11:0]), $signed(got[23:12]));
        end
      end else begin
        want = drive_due_q.pop_front();
        if (want[11:0] !== got[11:0] || want[23:12] !== got[23:12]) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("Drive mismatch: expected right %0d left %0d, got right %0d left %0d",
                     $signed(want[11:0]), $signed(want[23:12]),
                     $signed(got[11:0]), $signed(got[23:12]));
          end
        end
      end
    endfunction

    function int pending();
      return drive_due_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  wheel_drive_tracker tracker = new();
  bit tx_busy = 1'b1;
  bit rx_busy = 1'b1;
  int hold_request = 0;
  int idle_cycles = 0;

  dual_wheel_pi_speed_control uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] pack_speeds(int tr, int mr, int tl, int ml);
    return {ml[15:0], tl[15:0], mr[15:0], tr[15:0]};
  endfunction

  function automatic logic [63:0] random_speeds(speeds_kind_e kind, logic [1:0] push_up);
    logic [63:0] speeds;
    logic [15:0] tgt;
    int          err;
    speeds = {$urandom, $urandom};
    if (kind != SpeedsRandom) begin
      for (int w = 0; w < 2; w++) begin
        tgt = speeds[32*w +: 16];
        if (kind == SpeedsSteady) begin
          err = int'($urandom_range(0, 800)) - 400;
        end else begin
          err = int'($urandom_range(300, 1200));
          if (!push_up[w]) begin
            err = -err;
          end
        end
        speeds[32*w+16 +: 16] = tgt - err[15:0];
      end
    end
    return speeds;
  endfunction

  task automatic send_speeds(logic [63:0] speeds);
    int gap;
    gap = tx_busy ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= speeds;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: an optional stall before each transaction, or one long hold on request.
  initial begin : receiver
    int stall;
    wait (rst_ni);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = rx_busy ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.take_speeds(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.compare_drive(m_axis_tdata);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Timeout: no transaction for %0d cycles", IdleLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [63:0]  directed_q[$];
    logic [1:0]   push_up;
    int           pick;
    speeds_kind_e kind;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    directed_q.push_back(pack_speeds(0, 0, 0, 0));
    directed_q.push_back(pack_speeds(32767, -32768, -32768, 32767));
    directed_q.push_back(pack_speeds(-32768, 32767, 32767, -32768));
    directed_q.push_back(pack_speeds(975, 0, 0, 975));
    directed_q.push_back(pack_speeds(1, 0, 0, 1));
    directed_q.push_back(pack_speeds(-32768, -32768, 32767, 32767));
    directed_q.push_back(pack_speeds(0, 990, 990, 0));
    directed_q.push_back(pack_speeds(-5, 0, 5, 0));
    directed_q.push_back(pack_speeds(32767, 32767, -32768, -32768));
    directed_q.push_back(pack_speeds(0, 32767, -1, 0));
    directed_q.push_back(pack_speeds(1000, 0, 0, 1000));
    directed_q.push_back(pack_speeds(1023, 0, -1024, 0));
    directed_q.push_back(pack_speeds(21845, -21846, -21846, 21845));
    directed_q.push_back(pack_speeds(-1, -1, 0, -32768));
    foreach (directed_q[i]) begin
      send_speeds(directed_q[i]);
    end

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int chunk = 0; chunk < NumChunks; chunk++) begin
      push_up = 2'($urandom_range(0, 3));
      tx_busy = $urandom_range(0, 2) != 0;
      rx_busy = $urandom_range(0, 2) != 0;
      if (chunk == 3) begin
        tx_busy = 1'b0;
        hold_request = HoldCycles;
      end
      for (int n = 0; n < ChunkItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          kind = SpeedsRandom;
        end else if (pick < 70) begin
          kind = SpeedsSteady;
        end else begin
          kind = SpeedsWindup;
        end
        if ($urandom_range(0, 39) == 0) begin
          push_up = 2'($urandom_range(0, 3));
        end
        send_speeds(random_speeds(kind, push_up));
      end
      if (chunk == 6) begin
        @(negedge clk_i) s_axis_tvalid <= 1'b0;
        wait_drained();
      end
    end

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dwpi_pkg.sv
hw/rtl/dual_wheel_pi_speed_control.sv
bench/dual_wheel_pi_speed_control_test.sv
